/* rtl/sdcs_pkg.sv */
// Servo drive command sequencer: shared types, codes and constants.
// Used by sdcs_step and servo_drive_command_sequencer_top; depends on nothing.
package sdcs_pkg;

    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 32;
    localparam int unsigned InDataW   = 104;
    localparam int unsigned OutDataW  = 112;

    typedef enum logic [2:0] {
        MODE_CYCLE      = 3'd0,
        MODE_ENABLE     = 3'd1,
        MODE_DISABLE    = 3'd2,
        MODE_QUICKSTOP  = 3'd3,
        MODE_FAULTRESET = 3'd4,
        MODE_HOMING     = 3'd5,
        MODE_SETMODE    = 3'd6,
        MODE_TARGETS    = 3'd7
    } t_mode;

    typedef enum logic [3:0] {
        DS_NOT_READY      = 4'd0,
        DS_SW_ON_DISABLED = 4'd1,
        DS_READY          = 4'd2,
        DS_SWITCHED_ON    = 4'd3,
        DS_OP_ENABLED     = 4'd4,
        DS_QUICK_STOP     = 4'd5,
        DS_FAULT_REACTION = 4'd6,
        DS_FAULT          = 4'd7,
        DS_UNKNOWN        = 4'd8
    } t_drive_state;

    localparam logic [CfgIndexW-1:0] CFG_POSITION_MIN   = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_POSITION_MAX   = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_VELOCITY_LIMIT = 2'd2;
    localparam logic [CfgIndexW-1:0] CFG_TORQUE_LIMIT   = 2'd3;

    localparam logic [15:0] STW_MASK          = 16'h006F;
    localparam logic [15:0] STW_STATE_MASK    = 16'h004F;
    localparam logic [15:0] STW_SW_ON_DIS     = 16'h0040;
    localparam logic [15:0] STW_READY         = 16'h0021;
    localparam logic [15:0] STW_SWITCHED_ON   = 16'h0023;
    localparam logic [15:0] STW_OP_ENABLED    = 16'h0027;
    localparam logic [15:0] STW_QUICK_STOP    = 16'h0007;
    localparam logic [15:0] STW_FAULT_REACT   = 16'h000F;
    localparam logic [15:0] STW_FAULT         = 16'h0008;
    localparam logic [15:0] STW_NOT_READY     = 16'h0000;

    localparam logic [15:0] CTRL_IDLE         = 16'h0000;
    localparam logic [15:0] CTRL_SHUTDOWN     = 16'h0006;
    localparam logic [15:0] CTRL_SWITCH_ON    = 16'h0007;
    localparam logic [15:0] CTRL_ENABLE_OP    = 16'h000F;
    localparam logic [15:0] CTRL_FAULT_RESET  = 16'h0080;
    localparam int unsigned CTRL_QS_BIT       = 2;
    localparam int unsigned CTRL_HOME_BIT     = 4;
    localparam int unsigned CTRL_FR_BIT       = 7;
    localparam int unsigned STW_HOME_ATT_BIT  = 12;
    localparam int unsigned STW_TARGET_BIT    = 10;

    localparam logic signed [7:0] OP_MODE_HOMING = 8'sd6;

    typedef struct packed {
        logic [15:0]         command_word;
        logic                reset_pending;
        t_drive_state        decoded_state;
        logic [15:0]         last_status;
        logic signed [31:0]  position_target;
        logic signed [31:0]  velocity_target;
        logic signed [15:0]  torque_target;
        logic signed [7:0]   requested_mode;
    } t_state;

    typedef struct packed {
        logic signed [31:0] position_min;
        logic signed [31:0] position_max;
        logic [30:0]        velocity_limit;
        logic [14:0]        torque_limit;
    } t_limits;

    typedef struct packed {
        t_mode              mode;
        logic [15:0]        status_word;
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [15:0] new_torque;
        logic signed [7:0]  new_op_mode;
    } t_request;

    function automatic t_drive_state decode_sw(input logic [15:0] sw);
        logic [15:0]  m;
        logic [15:0]  s;
        t_drive_state d;
        m = sw & STW_MASK;
        s = m & STW_STATE_MASK;
        if (s == STW_SW_ON_DIS)          d = DS_SW_ON_DISABLED;
        else if (m == STW_READY)         d = DS_READY;
        else if (m == STW_SWITCHED_ON)   d = DS_SWITCHED_ON;
        else if (m == STW_OP_ENABLED)    d = DS_OP_ENABLED;
        else if (m == STW_QUICK_STOP)    d = DS_QUICK_STOP;
        else if (s == STW_FAULT_REACT)   d = DS_FAULT_REACTION;
        else if (s == STW_FAULT)         d = DS_FAULT;
        else if (s == STW_NOT_READY)     d = DS_NOT_READY;
        else                             d = DS_UNKNOWN;
        return d;
    endfunction

endpackage

/* rtl/servo_drive_command_sequencer_top.sv */
// Servo drive command sequencer, top level: state, limits and output register.
// Depends on sdcs_pkg and sdcs_step.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser mode, tdata operands
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata result
//  cfg       in         i_cfg_we                        i_cfg_index, i_cfg_data
//
// One request per clock while s_axis_tready is high; its result is registered and appears the cycle after accept.
// The state update runs through sdcs_step in the accept cycle, so requests chain back to back.
// s_axis_tready is low only while a result waits and m_axis_tready is low.
// Reset (synchronous, active low) loads the full-range limits and the idle drive state.
module servo_drive_command_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // status_word[15:0], new_position[47:16], new_velocity[79:48],
    // new_torque[95:80], new_op_mode[103:96]
    input  logic [sdcs_pkg::InDataW-1:0]        s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // control_word[15:0], position_out[47:16], velocity_out[79:48],
    // torque_out[95:80], op_mode_out[103:96], drive_state[107:104],
    // accepted[108], homing_done[109], zero[111:110]
    output logic [sdcs_pkg::OutDataW-1:0]       m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [sdcs_pkg::CfgIndexW-1:0]      i_cfg_index,
    input  logic [sdcs_pkg::CfgDataW-1:0]       i_cfg_data
);

    sdcs_pkg::t_state   r_state;
    sdcs_pkg::t_state   n_state;
    sdcs_pkg::t_limits  r_limits;
    sdcs_pkg::t_request w_req;
    logic               w_accepted;
    logic               w_in_fire;
    logic               w_homing;
    logic               r_out_valid;
    logic [sdcs_pkg::OutDataW-1:0] r_out_data;

    assign w_req.mode         = sdcs_pkg::t_mode'(s_axis_tuser);
    assign w_req.status_word  = s_axis_tdata[15:0];
    assign w_req.new_position = s_axis_tdata[47:16];
    assign w_req.new_velocity = s_axis_tdata[79:48];
    assign w_req.new_torque   = s_axis_tdata[95:80];
    assign w_req.new_op_mode  = s_axis_tdata[103:96];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    sdcs_step u_step (
        .i_req      (w_req),
        .i_state    (r_state),
        .i_limits   (r_limits),
        .o_state    (n_state),
        .o_accepted (w_accepted)
    );

    assign w_homing = n_state.last_status[sdcs_pkg::STW_HOME_ATT_BIT]
                   && n_state.last_status[sdcs_pkg::STW_TARGET_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.position_min   <= 32'sh8000_0000;
            r_limits.position_max   <= 32'sh7FFF_FFFF;
            r_limits.velocity_limit <= '1;
            r_limits.torque_limit   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdcs_pkg::CFG_POSITION_MIN:   r_limits.position_min   <= i_cfg_data;
                sdcs_pkg::CFG_POSITION_MAX:   r_limits.position_max   <= i_cfg_data;
                sdcs_pkg::CFG_VELOCITY_LIMIT: r_limits.velocity_limit <= i_cfg_data[30:0];
                sdcs_pkg::CFG_TORQUE_LIMIT:   r_limits.torque_limit   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.command_word    <= sdcs_pkg::CTRL_IDLE;
            r_state.reset_pending   <= 1'b0;
            r_state.decoded_state   <= sdcs_pkg::DS_UNKNOWN;
            r_state.last_status     <= '0;
            r_state.position_target <= '0;
            r_state.velocity_target <= '0;
            r_state.torque_target   <= '0;
            r_state.requested_mode  <= '0;
            r_out_valid             <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_data <= {2'b00, w_homing, w_accepted, 4'(n_state.decoded_state),
                           n_state.requested_mode, n_state.torque_target,
                           n_state.velocity_target, n_state.position_target,
                           n_state.command_word};
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> m_axis_tvalid)
        else $error("request accepted without a result");

    a_no_flag_on_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && (w_req.mode == sdcs_pkg::MODE_CYCLE || w_req.mode == sdcs_pkg::MODE_SETMODE
                      || w_req.mode == sdcs_pkg::MODE_TARGETS) |=> !m_axis_tdata[108])
        else $error("accepted flag raised for a request without one");

    a_pulse_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && w_req.mode == sdcs_pkg::MODE_CYCLE && r_state.reset_pending
        && r_state.command_word[sdcs_pkg::CTRL_FR_BIT]
        |=> (r_state.command_word == sdcs_pkg::CTRL_IDLE) && !r_state.reset_pending)
        else $error("fault reset pulse not ended by a cycle request");

    a_homing_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> m_axis_tdata[109] == (r_state.last_status[sdcs_pkg::STW_HOME_ATT_BIT]
                                           && r_state.last_status[sdcs_pkg::STW_TARGET_BIT]))
        else $error("homing flag does not match stored statusword");

endmodule

/* rtl/sdcs_step.sv */
// Servo drive command sequencer: next state and accepted flag for one request.
// Purely combinational; depends on sdcs_pkg.
module sdcs_step (
    input  sdcs_pkg::t_request i_req,
    input  sdcs_pkg::t_state   i_state,
    input  sdcs_pkg::t_limits  i_limits,
    output sdcs_pkg::t_state   o_state,
    output logic               o_accepted
);

    logic signed [32:0] w_vel;
    logic signed [32:0] w_vel_lim;
    logic signed [16:0] w_trq;
    logic signed [16:0] w_trq_lim;
    logic signed [31:0] w_pos_clamped;
    logic signed [31:0] w_vel_clamped;
    logic signed [15:0] w_trq_clamped;

    assign w_vel     = 33'(i_state.velocity_target);
    assign w_vel_lim = $signed({2'b00, i_limits.velocity_limit});
    assign w_trq     = 17'(i_state.torque_target);
    assign w_trq_lim = $signed({2'b00, i_limits.torque_limit});

    always_comb begin
        if (i_state.position_target < i_limits.position_min) begin
            w_pos_clamped = i_limits.position_min;
        end else if (i_state.position_target > i_limits.position_max) begin
            w_pos_clamped = i_limits.position_max;
        end else begin
            w_pos_clamped = i_state.position_target;
        end

        if (w_vel < -w_vel_lim) begin
            w_vel_clamped = 32'(-w_vel_lim);
        end else if (w_vel > w_vel_lim) begin
            w_vel_clamped = 32'(w_vel_lim);
        end else begin
            w_vel_clamped = i_state.velocity_target;
        end

        if (w_trq < -w_trq_lim) begin
            w_trq_clamped = 16'(-w_trq_lim);
        end else if (w_trq > w_trq_lim) begin
            w_trq_clamped = 16'(w_trq_lim);
        end else begin
            w_trq_clamped = i_state.torque_target;
        end
    end

    always_comb begin
        o_state    = i_state;
        o_accepted = 1'b0;
        case (i_req.mode)
            sdcs_pkg::MODE_CYCLE: begin
                o_state.last_status   = i_req.status_word;
                o_state.decoded_state = sdcs_pkg::decode_sw(i_req.status_word);
                if (i_state.reset_pending && i_state.command_word[sdcs_pkg::CTRL_FR_BIT]) begin
                    o_state.command_word  = sdcs_pkg::CTRL_IDLE;
                    o_state.reset_pending = 1'b0;
                end
                o_state.position_target = w_pos_clamped;
                o_state.velocity_target = w_vel_clamped;
                o_state.torque_target   = w_trq_clamped;
            end
            sdcs_pkg::MODE_ENABLE: begin
                case (i_state.decoded_state)
                    sdcs_pkg::DS_SW_ON_DISABLED: o_state.command_word = sdcs_pkg::CTRL_SHUTDOWN;
                    sdcs_pkg::DS_READY:          o_state.command_word = sdcs_pkg::CTRL_SWITCH_ON;
                    sdcs_pkg::DS_SWITCHED_ON:    o_state.command_word = sdcs_pkg::CTRL_ENABLE_OP;
                    sdcs_pkg::DS_OP_ENABLED:     o_accepted = 1'b1;
                    sdcs_pkg::DS_QUICK_STOP:     o_state.command_word = sdcs_pkg::CTRL_IDLE;
                    default: ;
                endcase
            end
            sdcs_pkg::MODE_DISABLE: begin
                o_state.command_word = sdcs_pkg::CTRL_SHUTDOWN;
                o_accepted           = 1'b1;
            end
            sdcs_pkg::MODE_QUICKSTOP: begin
                o_state.command_word[sdcs_pkg::CTRL_QS_BIT] = 1'b0;
                o_accepted = 1'b1;
            end
            sdcs_pkg::MODE_FAULTRESET: begin
                if (i_state.decoded_state == sdcs_pkg::DS_FAULT) begin
                    o_state.command_word  = sdcs_pkg::CTRL_FAULT_RESET;
                    o_state.reset_pending = 1'b1;
                    o_accepted            = 1'b1;
                end
            end
            sdcs_pkg::MODE_HOMING: begin
                if (i_state.decoded_state == sdcs_pkg::DS_OP_ENABLED) begin
                    o_state.requested_mode = sdcs_pkg::OP_MODE_HOMING;
                    o_state.command_word[sdcs_pkg::CTRL_HOME_BIT] = 1'b1;
                    o_accepted = 1'b1;
                end
            end
            sdcs_pkg::MODE_SETMODE: begin
                o_state.requested_mode = i_req.new_op_mode;
            end
            sdcs_pkg::MODE_TARGETS: begin
                o_state.position_target = i_req.new_position;
                o_state.velocity_target = i_req.new_velocity;
                o_state.torque_target   = i_req.new_torque;
            end
            default: ;
        endcase
    end

endmodule

/* tb/servo_drive_command_sequencer_top_tb.sv */
// Self-checking testbench for servo_drive_command_sequencer_top: a stimulus table, then
// drive sessions and noise under several limit settings, scored by a drive-state predictor.
// Depends on sdcs_pkg and the sequencer RTL only.
module servo_drive_command_sequencer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] STS_MASK        = 16'h006F;
    localparam logic [15:0] STS_STATE_MASK  = 16'h004F;
    localparam logic [15:0] STS_SW_ON_DIS   = 16'h0040;
    localparam logic [15:0] STS_READY       = 16'h0021;
    localparam logic [15:0] STS_SWITCHED_ON = 16'h0023;
    localparam logic [15:0] STS_OP_ENABLED  = 16'h0027;
    localparam logic [15:0] STS_QUICK_STOP  = 16'h0007;
    localparam logic [15:0] STS_FAULT_REACT = 16'h000F;
    localparam logic [15:0] STS_FAULT       = 16'h0008;
    localparam logic [15:0] STS_NOT_READY   = 16'h0000;

    localparam logic [15:0] CTL_OFF         = 16'h0000;
    localparam logic [15:0] CTL_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CTL_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CTL_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CTL_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CTL_HOMING_RUN  = 16'h001F;
    localparam logic [15:0] CTL_HOMING_QS   = 16'h001B;
    localparam int          CTL_QS_BIT      = 2;
    localparam int          CTL_HOME_BIT    = 4;
    localparam int          CTL_FR_BIT      = 7;
    localparam logic signed [7:0] HOMING_OP_MODE = 8'sd6;
    localparam int          HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic signed [7:0]  op_mode;
        logic signed [15:0] torque;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        logic [15:0]        status_word;
    } t_drive_req;

    typedef struct packed {
        logic [1:0]             pad;
        logic                   homing_done;
        logic                   accepted;
        sdcs_pkg::t_drive_state drive_state;
        logic signed [7:0]      op_mode;
        logic signed [15:0]     torque;
        logic signed [31:0]     velocity;
        logic signed [31:0]     position;
        logic [15:0]            control_word;
    } t_drive_result;

    typedef struct packed {
        logic                   on;
        logic [15:0]            cw;
        sdcs_pkg::t_drive_state ds;
        logic                   acc;
    } t_row_check;

    typedef struct packed {
        sdcs_pkg::t_mode        mode;
        logic [15:0]            sw;
        logic [31:0]            pos;
        logic [31:0]            vel;
        logic [15:0]            trq;
        logic [7:0]             opm;
        logic                   typed;
        logic [15:0]            cw;
        sdcs_pkg::t_drive_state ds;
        logic                   acc;
    } t_table_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [sdcs_pkg::InDataW-1:0]    s_axis_tdata;
    logic [2:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [sdcs_pkg::OutDataW-1:0]   m_axis_tdata;
    logic                            i_cfg_we;
    logic [sdcs_pkg::CfgIndexW-1:0]  i_cfg_index;
    logic [sdcs_pkg::CfgDataW-1:0]   i_cfg_data;

    t_row_check             check_hint;

    // predictor state and limits
    logic [15:0]            ctl_word;
    logic                   fr_armed;
    sdcs_pkg::t_drive_state drive_seen;
    logic [15:0]            last_status;
    logic signed [31:0]     pos_target;
    logic signed [31:0]     vel_target;
    logic signed [15:0]     trq_target;
    logic signed [7:0]      op_mode_req;
    logic signed [31:0]     pos_lo;
    logic signed [31:0]     pos_hi;
    logic [30:0]            vel_lim;
    logic [14:0]            trq_lim;

    t_drive_result          pending_results[$];
    int                     errors = 0;
    int                     items_sent = 0;
    int                     results_seen = 0;
    int                     accepted_seen = 0;
    int                     homing_seen = 0;
    int                     mode_count [8];
    bit                     calm = 1'b0;
    bit                     hold_off_req = 1'b0;

    t_table_row dir_rows [25] = '{
        '{sdcs_pkg::MODE_ENABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_UNKNOWN, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'h0060, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_SW_ON_DISABLED, 1'b0},
        '{sdcs_pkg::MODE_ENABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_SHUTDOWN,
          sdcs_pkg::DS_SW_ON_DISABLED, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'h0021, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_SHUTDOWN,
          sdcs_pkg::DS_READY, 1'b0},
        '{sdcs_pkg::MODE_ENABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_SWITCH_ON,
          sdcs_pkg::DS_READY, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'h0023, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_SWITCH_ON,
          sdcs_pkg::DS_SWITCHED_ON, 1'b0},
        '{sdcs_pkg::MODE_ENABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_ENABLE_OP,
          sdcs_pkg::DS_SWITCHED_ON, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'h1427, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_ENABLE_OP,
          sdcs_pkg::DS_OP_ENABLED, 1'b0},
        '{sdcs_pkg::MODE_ENABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_ENABLE_OP,
          sdcs_pkg::DS_OP_ENABLED, 1'b1},
        '{sdcs_pkg::MODE_HOMING, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_HOMING_RUN,
          sdcs_pkg::DS_OP_ENABLED, 1'b1},
        '{sdcs_pkg::MODE_QUICKSTOP, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_HOMING_QS,
          sdcs_pkg::DS_OP_ENABLED, 1'b1},
        '{sdcs_pkg::MODE_SETMODE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h80,
          1'b0, CTL_OFF, sdcs_pkg::DS_UNKNOWN, 1'b0},
        '{sdcs_pkg::MODE_TARGETS, 16'h0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 8'h00,
          1'b0, CTL_OFF, sdcs_pkg::DS_UNKNOWN, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'h0007, 32'h0, 32'h0, 16'h0, 8'h00, 1'b0, CTL_OFF,
          sdcs_pkg::DS_UNKNOWN, 1'b0},
        '{sdcs_pkg::MODE_ENABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_QUICK_STOP, 1'b0},
        '{sdcs_pkg::MODE_SETMODE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h7F, 1'b0, CTL_OFF,
          sdcs_pkg::DS_UNKNOWN, 1'b0},
        '{sdcs_pkg::MODE_TARGETS, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 8'h00,
          1'b0, CTL_OFF, sdcs_pkg::DS_UNKNOWN, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'h000F, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_FAULT_REACTION, 1'b0},
        '{sdcs_pkg::MODE_FAULTRESET, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_FAULT_REACTION, 1'b0},
        '{sdcs_pkg::MODE_CYCLE, 16'hFF98, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_FAULT, 1'b0},
        '{sdcs_pkg::MODE_FAULTRESET, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1,
          CTL_FAULT_RESET, sdcs_pkg::DS_FAULT, 1'b1},
        '{sdcs_pkg::MODE_DISABLE, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_SHUTDOWN,
          sdcs_pkg::DS_FAULT, 1'b1},
        '{sdcs_pkg::MODE_CYCLE, 16'h0008, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_SHUTDOWN,
          sdcs_pkg::DS_FAULT, 1'b0},
        '{sdcs_pkg::MODE_FAULTRESET, 16'h0000, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1,
          CTL_FAULT_RESET, sdcs_pkg::DS_FAULT, 1'b1},
        '{sdcs_pkg::MODE_CYCLE, 16'hFFFF, 32'h0, 32'h0, 16'h0, 8'h00, 1'b1, CTL_OFF,
          sdcs_pkg::DS_UNKNOWN, 1'b0}
    };

    servo_drive_command_sequencer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // status_word[15:0], new_position[47:16], new_velocity[79:48],
        // new_torque[95:80], new_op_mode[103:96]
        .s_axis_tdata  (s_axis_tdata),
        // mode[2:0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // control_word[15:0], position_out[47:16], velocity_out[79:48],
        // torque_out[95:80], op_mode_out[103:96], drive_state[107:104],
        // accepted[108], homing_done[109], zero[111:110]
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic sdcs_pkg::t_drive_state state_of_status(input logic [15:0] sw);
        logic [15:0] m;
        logic [15:0] s;
        m = sw & STS_MASK;
        s = m & STS_STATE_MASK;
        if (s == STS_SW_ON_DIS)      return sdcs_pkg::DS_SW_ON_DISABLED;
        if (m == STS_READY)          return sdcs_pkg::DS_READY;
        if (m == STS_SWITCHED_ON)    return sdcs_pkg::DS_SWITCHED_ON;
        if (m == STS_OP_ENABLED)     return sdcs_pkg::DS_OP_ENABLED;
        if (m == STS_QUICK_STOP)     return sdcs_pkg::DS_QUICK_STOP;
        if (s == STS_FAULT_REACT)    return sdcs_pkg::DS_FAULT_REACTION;
        if (s == STS_FAULT)          return sdcs_pkg::DS_FAULT;
        if (s == STS_NOT_READY)      return sdcs_pkg::DS_NOT_READY;
        return sdcs_pkg::DS_UNKNOWN;
    endfunction

    function automatic t_drive_result sequence_step(input sdcs_pkg::t_mode mode,
                                                    input t_drive_req rq);
        t_drive_result r;
        logic          acc;
        longint        v;
        longint        vl;
        int            t;
        int            tl;
        acc = 1'b0;
        case (mode)
            sdcs_pkg::MODE_CYCLE: begin
                last_status = rq.status_word;
                drive_seen  = state_of_status(last_status);
                if (fr_armed && ctl_word[CTL_FR_BIT]) begin
                    ctl_word = CTL_OFF;
                    fr_armed = 1'b0;
                end
                if (pos_target < pos_lo)      pos_target = pos_lo;
                else if (pos_target > pos_hi) pos_target = pos_hi;
                v  = vel_target;
                vl = vel_lim;
                if (v < -vl)     v = -vl;
                else if (v > vl) v = vl;
                vel_target = 32'(v);
                t  = trq_target;
                tl = trq_lim;
                if (t < -tl)     t = -tl;
                else if (t > tl) t = tl;
                trq_target = 16'(t);
            end
            sdcs_pkg::MODE_ENABLE: begin
                case (drive_seen)
                    sdcs_pkg::DS_SW_ON_DISABLED: ctl_word = CTL_SHUTDOWN;
                    sdcs_pkg::DS_READY:          ctl_word = CTL_SWITCH_ON;
                    sdcs_pkg::DS_SWITCHED_ON:    ctl_word = CTL_ENABLE_OP;
                    sdcs_pkg::DS_OP_ENABLED:     acc = 1'b1;
                    sdcs_pkg::DS_QUICK_STOP:     ctl_word = CTL_OFF;
                    default:                     ;
                endcase
            end
            sdcs_pkg::MODE_DISABLE: begin
                ctl_word = CTL_SHUTDOWN;
                acc = 1'b1;
            end
            sdcs_pkg::MODE_QUICKSTOP: begin
                ctl_word[CTL_QS_BIT] = 1'b0;
                acc = 1'b1;
            end
            sdcs_pkg::MODE_FAULTRESET: begin
                if (drive_seen == sdcs_pkg::DS_FAULT) begin
                    ctl_word = CTL_FAULT_RESET;
                    fr_armed = 1'b1;
                    acc = 1'b1;
                end
            end
            sdcs_pkg::MODE_HOMING: begin
                if (drive_seen == sdcs_pkg::DS_OP_ENABLED) begin
                    op_mode_req = HOMING_OP_MODE;
                    ctl_word[CTL_HOME_BIT] = 1'b1;
                    acc = 1'b1;
                end
            end
            sdcs_pkg::MODE_SETMODE: op_mode_req = rq.op_mode;
            default: begin
                pos_target = rq.position;
                vel_target = rq.velocity;
                trq_target = rq.torque;
            end
        endcase
        r.pad          = '0;
        r.homing_done  = last_status[12] & last_status[10];
        r.accepted     = acc;
        r.drive_state  = drive_seen;
        r.op_mode      = op_mode_req;
        r.torque       = trq_target;
        r.velocity     = vel_target;
        r.position     = pos_target;
        r.control_word = ctl_word;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_watch
        t_drive_result want;
        t_drive_result got;
        t_drive_req    rq;
        if (!i_rst_n) begin
            ctl_word    = CTL_OFF;
            fr_armed    = 1'b0;
            drive_seen  = sdcs_pkg::DS_UNKNOWN;
            last_status = '0;
            pos_target  = '0;
            vel_target  = '0;
            trq_target  = '0;
            op_mode_req = '0;
            pos_lo      = 32'sh8000_0000;
            pos_hi      = 32'sh7FFF_FFFF;
            vel_lim     = '1;
            trq_lim     = '1;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_drive_result'(m_axis_tdata);
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("control_word", 32'(want.control_word),
                                  32'(got.control_word));
                    compare_field("position_out", 32'(want.position), 32'(got.position));
                    compare_field("velocity_out", 32'(want.velocity), 32'(got.velocity));
                    compare_field("torque_out", 32'(want.torque), 32'(got.torque));
                    compare_field("op_mode_out", 32'(want.op_mode), 32'(got.op_mode));
                    compare_field("drive_state", 32'(want.drive_state), 32'(got.drive_state));
                    compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    compare_field("homing_done", 32'(want.homing_done), 32'(got.homing_done));
                    compare_field("padding", 32'(want.pad), 32'(got.pad));
                    accepted_seen += int'(got.accepted);
                    homing_seen   += int'(got.homing_done);
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdcs_pkg::CFG_POSITION_MIN:   pos_lo  = i_cfg_data;
                    sdcs_pkg::CFG_POSITION_MAX:   pos_hi  = i_cfg_data;
                    sdcs_pkg::CFG_VELOCITY_LIMIT: vel_lim = i_cfg_data[30:0];
                    sdcs_pkg::CFG_TORQUE_LIMIT:   trq_lim = i_cfg_data[14:0];
                    default:                      ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rq   = t_drive_req'(s_axis_tdata);
                want = sequence_step(sdcs_pkg::t_mode'(s_axis_tuser), rq);
                if (check_hint.on) begin
                    want.control_word = check_hint.cw;
                    want.drive_state  = check_hint.ds;
                    want.accepted     = check_hint.acc;
                end
                pending_results.push_back(want);
                mode_count[s_axis_tuser]++;
            end
        end
    end

    // result side: random back-pressure bursts, one long hold-off on request
    initial begin : result_sink
        int left;
        left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                left = HOLD_OFF_CYCLES - 1;
            end else if (left > 0) begin
                left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                left = $urandom_range(0, 9);
            end else begin
                m_axis_tready <= 1'b1;
                left = calm ? 0 : $urandom_range(0, 15);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("servo_drive_command_sequencer_top regression: fail");
        $finish;
    end

    task automatic offer(input sdcs_pkg::t_mode m, input t_drive_req p, input t_row_check h);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tuser  <= m;
        check_hint    <= h;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // drop valid and hold until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [30:0] vel, input logic [14:0] trq);
        logic [sdcs_pkg::CfgIndexW-1:0] regs [4];
        logic [31:0]                    vals [4];
        regs = '{sdcs_pkg::CFG_POSITION_MIN, sdcs_pkg::CFG_POSITION_MAX,
                 sdcs_pkg::CFG_VELOCITY_LIMIT, sdcs_pkg::CFG_TORQUE_LIMIT};
        vals = '{lo, hi, 32'(vel), 32'(trq)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_drive_req random_payload();
        t_drive_req  p;
        int unsigned off;
        logic [31:0] v;
        logic [15:0] t;
        off = $urandom_range(0, 6);
        p.status_word = 16'($urandom);
        p.op_mode     = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            p.position = ($urandom_range(0, 1) ? pos_lo : pos_hi) + off - 3;
        else
            p.position = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            v = {1'b0, vel_lim} + off - 3;
            p.velocity = $urandom_range(0, 1) ? v : -v;
        end else begin
            p.velocity = $urandom;
        end
        if ($urandom_range(0, 3) == 0) begin
            t = {1'b0, trq_lim} + 16'(off) - 16'd3;
            p.torque = $urandom_range(0, 1) ? t : -t;
        end else begin
            p.torque = 16'($urandom);
        end
        return p;
    endfunction

    task automatic send_cmd(input sdcs_pkg::t_mode m);
        offer(m, random_payload(), '0);
    endtask

    task automatic send_status(input logic [15:0] code);
        t_drive_req p;
        p = random_payload();
        p.status_word = code | (p.status_word & ~STS_MASK);
        offer(sdcs_pkg::MODE_CYCLE, p, '0);
    endtask

    // well-formed bring-up to operation enabled, some work, then a way out
    task automatic drive_session();
        int n;
        send_status(STS_SW_ON_DIS);
        send_cmd(sdcs_pkg::MODE_ENABLE);
        send_status(STS_READY);
        send_cmd(sdcs_pkg::MODE_ENABLE);
        send_status(STS_SWITCHED_ON);
        send_cmd(sdcs_pkg::MODE_ENABLE);
        send_status(STS_OP_ENABLED);
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 6))
                0: send_cmd(sdcs_pkg::MODE_ENABLE);
                1: send_cmd(sdcs_pkg::MODE_HOMING);
                2: send_cmd(sdcs_pkg::MODE_SETMODE);
                3: send_cmd(sdcs_pkg::MODE_TARGETS);
                4: send_status(STS_OP_ENABLED);
                5: send_cmd(sdcs_pkg::MODE_QUICKSTOP);
                default: begin
                    send_status(STS_QUICK_STOP);
                    send_cmd(sdcs_pkg::MODE_ENABLE);
                    send_status(STS_OP_ENABLED);
                end
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                send_status(STS_FAULT_REACT);
                send_status(STS_FAULT);
                send_cmd(sdcs_pkg::MODE_FAULTRESET);
                if ($urandom_range(0, 1)) begin
                    if ($urandom_range(0, 1))
                        send_cmd(sdcs_pkg::MODE_DISABLE);
                    else
                        send_cmd(sdcs_pkg::MODE_QUICKSTOP);
                end
                send_status($urandom_range(0, 1) ? STS_SW_ON_DIS : STS_FAULT);
                send_cmd(sdcs_pkg::MODE_FAULTRESET);
                send_status(16'($urandom));
            end
            1: begin
                send_cmd(sdcs_pkg::MODE_DISABLE);
                send_status(STS_SW_ON_DIS);
            end
            2: begin
                send_cmd(sdcs_pkg::MODE_QUICKSTOP);
                send_status(STS_QUICK_STOP);
                send_cmd(sdcs_pkg::MODE_ENABLE);
            end
            default: send_status(STS_NOT_READY);
        endcase
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int n;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                drive_session();
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_cmd(sdcs_pkg::t_mode'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin : stimulus
        t_drive_req  p;
        t_row_check  h;
        logic [31:0] a;
        logic [31:0] b;
        int          waited;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= sdcs_pkg::MODE_CYCLE;
        check_hint    <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= sdcs_pkg::CFG_POSITION_MIN;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            p.status_word = dir_rows[k].sw;
            p.position    = dir_rows[k].pos;
            p.velocity    = dir_rows[k].vel;
            p.torque      = dir_rows[k].trq;
            p.op_mode     = dir_rows[k].opm;
            h.on          = dir_rows[k].typed;
            h.cw          = dir_rows[k].cw;
            h.ds          = dir_rows[k].ds;
            h.acc         = dir_rows[k].acc;
            offer(dir_rows[k].mode, p, h);
        end
        run_random(60);

        settle();
        load_limits(-32'($urandom_range(0, 100000)), 32'($urandom_range(0, 100000)),
                    31'($urandom_range(0, 200000)), 15'($urandom_range(0, 1000)));
        run_random(80);
        hold_off_req = 1'b1;
        run_random(40);
        settle();
        run_random(60);

        settle();
        load_limits('0, '0, '0, '0);
        run_random(100);

        // inverted position window: min above max
        settle();
        load_limits(32'($urandom_range(1, 1000)), -32'($urandom_range(1, 1000)), '1, '1);
        run_random(100);

        settle();
        load_limits(32'h8000_0000, 32'h7FFF_FFFF, 31'($urandom_range(0, 50)), '1);
        run_random(100);

        settle();
        a = $urandom;
        b = $urandom;
        if ($signed(a) > $signed(b))
            load_limits(b, a, 31'($urandom), 15'($urandom));
        else
            load_limits(a, b, 31'($urandom), 15'($urandom));
        calm = 1'b1;
        run_random(140);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            errors += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        $display("covered %0d requests (%0d cycle items) over six limit settings,",
                 items_sent, mode_count[sdcs_pkg::MODE_CYCLE]);
        $display("%0d results checked, %0d commands accepted, %0d with homing complete",
                 results_seen, accepted_seen, homing_seen);
        if (errors == 0) begin
            $display("servo_drive_command_sequencer_top regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("servo_drive_command_sequencer_top regression: fail");
        end
        $finish;
    end

endmodule
